@@ sv/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; pulled in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is asserted (active low)
`define BAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also runs through reset
`define BAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/bas_pkg.sv @@
// shared types and constants of the bridge converter serial reader
// no dependencies; used by bas_core, bridge_adc_serial_reader, adc_link_checker and testbench
package bas_pkg;

    localparam int unsigned BAS_DATA_BITS = 24;
    localparam int unsigned VALUE_W       = 24;
    localparam int unsigned HALF_W        = 8;
    localparam int unsigned WDOG_W        = 32;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;

    localparam logic [HALF_W-1:0] HALF_RST = 8'd40;
    localparam logic [WDOG_W-1:0] WDOG_RST = 32'd40000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG    = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAIN = 2'd3
    } t_phase;

    typedef struct packed {
        logic [HALF_W-1:0] half_period_ticks;
        logic [WDOG_W-1:0] watchdog_ticks;
    } t_cfg;

    typedef struct packed {
        logic                      clock_level;
        logic                      value_valid;
        logic signed [VALUE_W-1:0] value;
        logic                      watchdog_fired;
    } t_result;

endpackage

@@ sv/bas_core.sv @@
// link sequencer, shift register, result formatting and watchdog
// depends on bas_pkg; result is combinational from state and the current tick
module bas_core import bas_pkg::*; #(
    parameter int unsigned DATA_BITS = BAS_DATA_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_data_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [HALF_W-1:0]    r_phase_timer, n_phase_timer;
    logic [DATA_BITS-1:0] r_shift_word, n_shift_word;
    logic                 r_previous_level;
    logic [WDOG_W-1:0]    r_timeout_counter, n_timeout_counter;

    logic                      w_done;
    logic [CNT_W-1:0]          w_bit_inc;
    logic [WDOG_W-1:0]         w_limit;
    logic [WDOG_W-1:0]         w_count_inc;
    logic signed [VALUE_W-1:0] w_word;
    logic                      w_valid;

    // signed reading of the received word, clamped to the output range
    generate
        if (DATA_BITS > VALUE_W) begin : g_sat
            logic [DATA_BITS-VALUE_W:0] w_top;
            assign w_top  = r_shift_word[DATA_BITS-1:VALUE_W-1];
            assign w_word = ((&w_top) || !(|w_top)) ? r_shift_word[VALUE_W-1:0] :
                            (w_top[DATA_BITS-VALUE_W] ? VALUE_MIN : VALUE_MAX);
        end else begin : g_ext
            assign w_word = VALUE_W'($signed(r_shift_word));
        end
    endgenerate

    assign w_done      = (r_phase_timer >= i_cfg.half_period_ticks);
    assign w_bit_inc   = r_bit_count + 1'b1;
    assign w_limit     = (i_cfg.watchdog_ticks == '0) ? WDOG_W'(1) : i_cfg.watchdog_ticks;
    assign w_count_inc = r_timeout_counter + 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_phase_timer = r_phase_timer;
        n_shift_word  = r_shift_word;
        w_valid       = 1'b0;
        o_result      = '0;
        case (r_phase)
            PH_IDLE: begin
                if (r_previous_level && !i_data_level) begin
                    n_phase              = PH_HIGH;
                    n_phase_timer        = HALF_W'(1);
                    n_bit_count          = '0;
                    n_shift_word         = '0;
                    o_result.clock_level = 1'b1;
                end
            end
            PH_HIGH: begin
                if (w_done) begin
                    n_phase       = PH_LOW;
                    n_phase_timer = HALF_W'(1);
                end else begin
                    n_phase_timer        = r_phase_timer + 1'b1;
                    o_result.clock_level = 1'b1;
                end
            end
            PH_LOW: begin
                if (w_done) begin
                    n_shift_word         = {r_shift_word[DATA_BITS-2:0], i_data_level};
                    n_bit_count          = w_bit_inc;
                    n_phase              = (w_bit_inc >= CNT_W'(DATA_BITS)) ? PH_GAIN : PH_HIGH;
                    n_phase_timer        = HALF_W'(1);
                    o_result.clock_level = 1'b1;
                end else begin
                    n_phase_timer = r_phase_timer + 1'b1;
                end
            end
            PH_GAIN: begin
                // extra pulse keeps channel a, gain 128 for the next conversion
                if (w_done) begin
                    n_phase        = PH_IDLE;
                    n_phase_timer  = '0;
                    n_bit_count    = '0;
                    w_valid        = 1'b1;
                    o_result.value = w_word;
                end else begin
                    n_phase_timer        = r_phase_timer + 1'b1;
                    o_result.clock_level = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // watchdog restarts on every result and on expiry
        n_timeout_counter = w_count_inc;
        if (w_valid) begin
            n_timeout_counter = '0;
        end else if (w_count_inc >= w_limit) begin
            n_timeout_counter       = '0;
            o_result.watchdog_fired = 1'b1;
        end
        o_result.value_valid = w_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_bit_count       <= '0;
            r_phase_timer     <= '0;
            r_shift_word      <= '0;
            r_previous_level  <= 1'b1;
            r_timeout_counter <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_bit_count       <= n_bit_count;
            r_phase_timer     <= n_phase_timer;
            r_shift_word      <= n_shift_word;
            r_previous_level  <= i_data_level;
            r_timeout_counter <= n_timeout_counter;
        end
    end

endmodule

@@ sv/bridge_adc_serial_reader.sv @@
// top level of the bridge converter serial reader: config registers, output skid
// depends on bas_pkg, bas_core and assert_macros.svh
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_data_level
//  output    out        o_valid / i_stall          o_clock_level, o_value_valid,
//                                                  o_value, o_watchdog_fired
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one word in gives one word out; a word can be taken every cycle while o_stall is low, and its result is registered
// in the output register or the skid; the rate is set by the single pass through the sequencer in bas_core
// reset is synchronous, active low; config returns to 40 ticks per phase
//   and a 40000000 tick watchdog, the sequencer to idle
// a two-entry output (register plus skid) keeps taking input while one word waits;
//   o_stall rises only when both entries are full
`include "assert_macros.svh"

module bridge_adc_serial_reader import bas_pkg::*; #(
    parameter int unsigned DATA_BITS = BAS_DATA_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_data_level,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_clock_level,
    output logic                      o_value_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_watchdog_fired,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_result w_result;

    // output register and skid entry
    logic    r_out_valid;
    t_result r_out;
    logic    r_skd_valid;
    t_result r_skd;

    logic w_in_acc;
    logic w_out_acc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skd_valid;
    assign w_in_acc    = i_valid && !r_skd_valid;
    assign w_out_acc   = r_out_valid && !i_stall;

    // config writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_RST;
            r_cfg.watchdog_ticks    <= WDOG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data[HALF_W-1:0];
                CFG_WATCHDOG:    r_cfg.watchdog_ticks    <= i_cfg_data[WDOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bas_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_acc),
        .i_data_level (i_data_level),
        .i_cfg        (r_cfg),
        .o_result     (w_result)
    );

    // valid flags of the two output entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || w_out_acc) begin
            // output slot frees up: skid drains first, else the new word goes in
            if (r_skd_valid) begin
                r_skd_valid <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skd_valid <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_acc) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
            end else if (w_in_acc) begin
                r_out <= w_result;
            end
        end else if (w_in_acc) begin
            r_skd <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_clock_level    = r_out.clock_level;
    assign o_value_valid    = r_out.value_valid;
    assign o_value          = r_out.value;
    assign o_watchdog_fired = r_out.watchdog_fired;

    // skid holds a word only behind a full output register
    `BAS_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skd_valid |-> r_out_valid, "skid valid with output empty")
    // a word taken in while the output is held must land in the skid
    `BAS_ASSERT(a_skid_fill, i_clk, i_rst_n, (w_in_acc && r_out_valid && !w_out_acc) |=> r_skd_valid, "accepted word lost behind stalled output")
    // a new result restarts the watchdog, so both flags never meet
    `BAS_ASSERT(a_no_fire_with_value, i_clk, i_rst_n, o_valid |-> !(o_value_valid && o_watchdog_fired), "timeout flagged on a result word")
    // value field is zero when no result is presented
    `BAS_ASSERT(a_value_zero, i_clk, i_rst_n, (o_valid && !o_value_valid) |-> (o_value == '0), "value nonzero without result")

endmodule

@@ tb/adc_link_checker.sv @@
// checker for the bridge converter serial reader: predicts every output word
// from the accepted sample words and the register writes, then compares
// depends on bas_pkg; instantiated beside the block by testbench
module adc_link_checker import bas_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_smp_valid,
    input  logic                      i_smp_stall,
    input  logic                      i_smp_level,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic                      i_clock_level,
    input  logic                      i_value_valid,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_watchdog_fired,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_conversions,
    output int                        o_timeouts
);

    // sequencer copy
    t_phase                   seq_phase;
    int                       bits_taken;
    logic [HALF_W-1:0]        phase_tick;
    logic [BAS_DATA_BITS-1:0] rx_word;
    logic                     last_level;
    logic [WDOG_W-1:0]        idle_ticks;
    logic [HALF_W-1:0]        half_cfg;
    logic [WDOG_W-1:0]        wdog_cfg;

    t_result expected_link_out[$];

    always @(posedge i_clk) begin : sequencer_model
        logic        done;
        t_result     exp_w;
        t_result     got;
        longint      full;
        logic [WDOG_W-1:0] limit;

        if (!i_rst_n) begin
            seq_phase  = PH_IDLE;
            bits_taken = 0;
            phase_tick = '0;
            rx_word    = '0;
            last_level = 1'b1;
            idle_ticks = '0;
            half_cfg   = HALF_RST;
            wdog_cfg   = WDOG_RST;
            expected_link_out.delete();
            o_errors      = 0;
            o_conversions = 0;
            o_timeouts    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_PERIOD: half_cfg = i_cfg_data[HALF_W-1:0];
                    CFG_WATCHDOG:    wdog_cfg = i_cfg_data[WDOG_W-1:0];
                    default: ;
                endcase
            end

            if (i_smp_valid && !i_smp_stall) begin
                exp_w = '0;
                done  = (phase_tick >= half_cfg);
                case (seq_phase)
                    PH_IDLE: begin
                        if (last_level && !i_smp_level) begin
                            seq_phase  = PH_HIGH;
                            phase_tick = 8'd1;
                            bits_taken = 0;
                            rx_word    = '0;
                            exp_w.clock_level = 1'b1;
                        end
                    end
                    PH_HIGH: begin
                        if (done) begin
                            seq_phase  = PH_LOW;
                            phase_tick = 8'd1;
                        end else begin
                            phase_tick = phase_tick + 8'd1;
                            exp_w.clock_level = 1'b1;
                        end
                    end
                    PH_LOW: begin
                        if (done) begin
                            rx_word    = {rx_word[BAS_DATA_BITS-2:0], i_smp_level};
                            bits_taken = bits_taken + 1;
                            seq_phase  = (bits_taken >= BAS_DATA_BITS) ? PH_GAIN : PH_HIGH;
                            phase_tick = 8'd1;
                            exp_w.clock_level = 1'b1;
                        end else begin
                            phase_tick = phase_tick + 8'd1;
                        end
                    end
                    default: begin
                        if (done) begin
                            seq_phase  = PH_IDLE;
                            phase_tick = '0;
                            bits_taken = 0;
                            // two's complement of the received word, clamped to value
                            full = longint'(rx_word);
                            if (rx_word[BAS_DATA_BITS-1])
                                full = full - (longint'(1) << BAS_DATA_BITS);
                            if (full > longint'(VALUE_MAX))
                                full = longint'(VALUE_MAX);
                            if (full < longint'(VALUE_MIN))
                                full = longint'(VALUE_MIN);
                            exp_w.value_valid = 1'b1;
                            exp_w.value       = full[VALUE_W-1:0];
                        end else begin
                            phase_tick = phase_tick + 8'd1;
                            exp_w.clock_level = 1'b1;
                        end
                    end
                endcase
                last_level = i_smp_level;

                // a result restarts the count, so no flag on that tick
                if (exp_w.value_valid) begin
                    idle_ticks = '0;
                end else begin
                    limit      = (wdog_cfg == '0) ? 32'd1 : wdog_cfg;
                    idle_ticks = idle_ticks + 32'd1;
                    if (idle_ticks >= limit) begin
                        exp_w.watchdog_fired = 1'b1;
                        idle_ticks = '0;
                    end
                end
                expected_link_out.push_back(exp_w);
            end

            if (i_res_valid && !i_res_stall) begin
                got.clock_level    = i_clock_level;
                got.value_valid    = i_value_valid;
                got.value          = i_value;
                got.watchdog_fired = i_watchdog_fired;
                if (got.value_valid)
                    o_conversions = o_conversions + 1;
                if (got.watchdog_fired)
                    o_timeouts = o_timeouts + 1;
                if (expected_link_out.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: output word with none predicted: clock %0b valid %0b value %0d fired %0b",
                             $time, got.clock_level, got.value_valid, got.value,
                             got.watchdog_fired);
                end else begin
                    exp_w = expected_link_out.pop_front();
                    if (got.clock_level !== exp_w.clock_level) begin
                        o_errors = o_errors + 1;
                        $display("%0t: clock_level expected %0b got %0b",
                                 $time, exp_w.clock_level, got.clock_level);
                    end
                    if (got.value_valid !== exp_w.value_valid) begin
                        o_errors = o_errors + 1;
                        $display("%0t: value_valid expected %0b got %0b",
                                 $time, exp_w.value_valid, got.value_valid);
                    end
                    if (got.value !== exp_w.value) begin
                        o_errors = o_errors + 1;
                        $display("%0t: value expected %0d got %0d",
                                 $time, exp_w.value, got.value);
                    end
                    if (got.watchdog_fired !== exp_w.watchdog_fired) begin
                        o_errors = o_errors + 1;
                        $display("%0t: watchdog_fired expected %0b got %0b",
                                 $time, exp_w.watchdog_fired, got.watchdog_fired);
                    end
                end
            end
        end
        o_pending = expected_link_out.size();
    end

endmodule

@@ tb/testbench.sv @@
// top of the bridge converter serial reader bench: clock, reset, sample and
// register stimulus, receiver stalls, verdict
// depends on bas_pkg, bridge_adc_serial_reader and adc_link_checker
module testbench;
    import bas_pkg::*;

    // generous bound on the length of the run
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // indexes with no register behind them, written once to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      i_data_level = 1'b1;
    logic                      i_stall      = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data   = '0;
    logic                      o_stall;
    logic                      o_valid;
    logic                      o_clock_level;
    logic                      o_value_valid;
    logic signed [VALUE_W-1:0] o_value;
    logic                      o_watchdog_fired;
    logic                      o_cfg_ready;

    int mismatches;
    int pending;
    int conversions;
    int timeouts;

    // idling odds in percent, changed between phases of the run
    int send_idle_pct  = 24;
    int recv_stall_pct = 59;

    int unsigned half_ticks  = 32'(HALF_RST);   // half period the block is running with
    int unsigned n_samples   = 0;
    int unsigned n_settings  = 0;
    int unsigned cycle_count = 0;

    always #5 i_clk = ~i_clk;

    bridge_adc_serial_reader u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_level     (i_data_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_clock_level    (o_clock_level),
        .o_value_valid    (o_value_valid),
        .o_value          (o_value),
        .o_watchdog_fired (o_watchdog_fired),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    adc_link_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_smp_valid      (i_valid),
        .i_smp_stall      (o_stall),
        .i_smp_level      (i_data_level),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_clock_level    (o_clock_level),
        .i_value_valid    (o_value_valid),
        .i_value          (o_value),
        .i_watchdog_fired (o_watchdog_fired),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (mismatches),
        .o_pending        (pending),
        .o_conversions    (conversions),
        .o_timeouts       (timeouts)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one data-line sample word; valid stays high after acceptance so that a
    // following word never lowers and raises it within one time step
    task automatic put_level(input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_level <= lvl;
        do @(posedge i_clk); while (o_stall);
        n_samples++;
        @(negedge i_clk);
    endtask

    // register writes happen only once every predicted word has come back;
    // valid is held across back-to-back writes, only index and data move
    task automatic configure(input logic [HALF_W-1:0] half, input logic [WDOG_W-1:0] wdog,
                             input bit spare);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] dat [4];
        int                    n;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        // upper data bits are junk for the 8-bit half period register
        idx[0] = CFG_HALF_PERIOD;
        dat[0] = {24'($urandom), half};
        idx[1] = CFG_WATCHDOG;
        dat[1] = wdog;
        idx[2] = CFG_SPARE_2;
        dat[2] = $urandom;
        idx[3] = CFG_SPARE_3;
        dat[3] = $urandom;
        n = spare ? 4 : 2;
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < n; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        half_ticks = 32'(half);
        n_settings++;
    endtask

    // converter side of one conversion: falling data edge, then the word laid out so
    // that each bit sits on the tick the block samples it (end of each low phase);
    // a nonzero cut stops the sequence early to leave a broken conversion
    task automatic send_conversion(input logic [BAS_DATA_BITS-1:0] word, input bit noisy,
                                   input int unsigned cut);
        int unsigned slot;
        int unsigned len;
        logic        lvl;
        slot = (half_ticks == 0) ? 1 : half_ticks;   // zero half period runs as one
        len  = (2 * BAS_DATA_BITS + 1) * slot;
        if (cut > 0 && cut < len)
            len = cut;
        lvl = 1'b0;
        put_level(1'b0);
        for (int unsigned t = 1; t <= len; t++) begin
            if (t % (2 * slot) == 0 && t / (2 * slot) <= BAS_DATA_BITS)
                lvl = word[BAS_DATA_BITS - t / (2 * slot)];
            else if (noisy)
                lvl = 1'($urandom_range(1));   // edges mid conversion must be ignored
            put_level(lvl);
        end
    endtask

    // random settings, each followed by two picks among a full conversion, a broken one and noise
    task automatic random_stretch(input int n_set);
        logic [HALF_W-1:0] h;
        logic [WDOG_W-1:0] w;
        int                pick;
        int unsigned       len;
        repeat (n_set) begin
            pick = $urandom_range(9);
            h = (pick == 0) ? 8'd0 : 8'($urandom_range(1, (pick > 7) ? 6 : 2));
            case ($urandom_range(3))
                0:       w = '0;
                1:       w = $urandom_range(1, 60);
                2:       w = $urandom;
                default: w = $urandom_range(61, 400);
            endcase
            configure(h, w, 1'b0);
            len = (2 * BAS_DATA_BITS + 1) * ((h == 0) ? 1 : h);
            repeat (2) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_conversion($urandom, 1'($urandom_range(1)), 0);
                else if (pick < 85)
                    send_conversion($urandom, 1'b1, $urandom_range(1, len - 1));
                else
                    repeat ($urandom_range(1, 30)) put_level(1'($urandom_range(1)));
                // data line back high so the next falling edge can start a conversion
                repeat ($urandom_range(1, 4)) put_level(1'b1);
            end
        end
    endtask

    initial begin : stimulus
        logic [BAS_DATA_BITS-1:0] corner_words [2];
        corner_words[0] = {1'b1, {(BAS_DATA_BITS-1){1'b0}}};
        corner_words[1] = {1'b0, {(BAS_DATA_BITS-1){1'b1}}};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver stalls often
        // low level on the very first word starts a conversion at reset settings;
        // it is cut a few ticks into the first low phase
        send_conversion('0, 1'b0, 32'(HALF_RST) + 32'd5);

        // zero half period (runs as one), zero watchdog limit (flag on every word
        // without a result), also touch the unused register indexes
        configure(8'd0, 32'd0, 1'b1);
        // ones finish the broken conversion and leave the line high
        repeat (2 * BAS_DATA_BITS + 2) put_level(1'b1);
        foreach (corner_words[k]) begin
            send_conversion(corner_words[k], 1'b0, 0);
            repeat (2) put_level(1'b1);
        end

        // sender idles often, receiver stalls lightly
        send_idle_pct  <= 59;
        recv_stall_pct <= 24;
        random_stretch(1);

        // no idling at all; longest half period with the largest watchdog limit,
        // cut one tick into the first low phase
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        configure(8'd255, 32'hFFFF_FFFF, 1'b0);
        send_conversion($urandom, 1'b1, 256);
        repeat (3) put_level(1'b1);

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("covered %0d data-line samples under %0d register settings",
                 n_samples, n_settings);
        $display("checked %0d conversion results and %0d watchdog timeouts",
                 conversions, timeouts);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
